@@ rtl/llr_pkg.sv @@
// Shared types and constants for the LFU/LRU replacement core.
// No dependencies; imported by llr_cmp, lfu_lru_replacement_core and tb.
package llr_pkg;

  localparam int KEY_W   = 64;
  localparam int STAMP_W = 64;
  localparam int CAP_W   = 7;
  localparam int OCC_W   = 7;
  localparam int OUT_W   = 80;

  // Request kinds
  localparam logic FUNC_ACCESS = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_EVICT,
    ST_DONE
  } state_t;

  // Outcome of one pass through the shared compare unit
  typedef struct packed {
    logic lt;      // (a_freq, a_stamp) orders strictly before (b_freq, b_stamp)
    logic eq;      // count and stamp both equal
    logic key_eq;  // keys equal
  } cmp_res_t;

endpackage

@@ rtl/lfu_lru_replacement_core.sv @@
// Top level of the LFU replacement core with LRU tie-break: sequencer,
// scan registers and result register. Depends on llr_pkg, llr_mem, llr_cmp.
//
// Usage:
// - Input channel (in_*): one beat per request. in_tuser[0] is the request
//   kind (0 access, 1 remove), in_tdata[63:0] the key.
// - Result channel (out_*): one beat per request with hit, evict flag,
//   evicted key and occupancy after the request.
// - cfg_wr_en/cfg_wr_data write the capacity; values above ENTRIES act as
//   ENTRIES. Write it only while no request is in flight.
// - Each request scans all ENTRIES+1 slots, one per cycle through one read
//   port and one compare unit, then passes DECIDE (and EVICT when an entry
//   is evicted) and DONE. The result goes valid as in_tready rises, so a new
//   request is taken only after the previous result has been registered.
// - Reset runs a clearing pass over all ENTRIES+1 memory slots; in_tready
//   stays low until it ends. Capacity resets to ENTRIES.
// - A stalled receiver holds the result in the output register; the next
//   request is accepted and scanned meanwhile, and waits at its end until
//   the output register frees up.
module lfu_lru_replacement_core #(
  parameter int ENTRIES   = 64,
  parameter int FREQ_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // in_tdata: [63:0] key
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [llr_pkg::KEY_W-1:0]     in_tdata,
  // in_tuser: [0] func
  input  logic [0:0]                    in_tuser,
  // out_tdata: [0] hit, [1] evict_valid, [65:2] evict_key,
  //            [72:66] occupancy, [79:73] zero
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [llr_pkg::OUT_W-1:0]     out_tdata,
  input  logic                          cfg_wr_en,
  input  logic [llr_pkg::CAP_W-1:0]     cfg_wr_data
);
  import llr_pkg::*;

  localparam int SLOTS  = ENTRIES + 1;
  localparam int IDX_W  = $clog2(SLOTS);
  localparam int SCN_W  = $clog2(SLOTS + 1);
  localparam int CNT_W  = SCN_W;
  localparam int CAPR_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int CMP_W  = CAPR_W + 1;
  localparam int MEM_W  = 1 + KEY_W + FREQ_BITS + STAMP_W;
  localparam int PAD_W  = OUT_W - (2 + KEY_W + OCC_W);

  // Control registers
  state_t             state_r,   state_nxt;
  logic [SCN_W-1:0]   idx_r,     idx_nxt;
  logic               d_vld_r,   d_vld_nxt;
  logic [STAMP_W-1:0] reqnum_r,  reqnum_nxt;
  logic [CNT_W-1:0]   cnt_r,     cnt_nxt;
  logic [CAPR_W-1:0]  cap_r,     cap_nxt;
  logic               out_vld_r, out_vld_nxt;

  // Request and scan registers
  logic [IDX_W-1:0]     d_idx_r,      d_idx_nxt;
  logic                 func_r,       func_nxt;
  logic [KEY_W-1:0]     key_r,        key_nxt;
  logic [STAMP_W-1:0]   stamp_r,      stamp_nxt;
  logic                 hit_r,        hit_nxt;
  logic [IDX_W-1:0]     hit_idx_r,    hit_idx_nxt;
  logic [FREQ_BITS-1:0] hit_freq_r,   hit_freq_nxt;
  logic                 free_r,       free_nxt;
  logic [IDX_W-1:0]     free_idx_r,   free_idx_nxt;
  logic                 best_r,       best_nxt;
  logic [IDX_W-1:0]     best_idx_r,   best_idx_nxt;
  logic [KEY_W-1:0]     best_key_r,   best_key_nxt;
  logic [FREQ_BITS-1:0] best_freq_r,  best_freq_nxt;
  logic [STAMP_W-1:0]   best_stamp_r, best_stamp_nxt;
  logic                 ev_r,         ev_nxt;
  logic [IDX_W-1:0]     ev_idx_r,     ev_idx_nxt;
  logic [KEY_W-1:0]     ev_key_r,     ev_key_nxt;
  logic [OUT_W-1:0]     out_data_r,   out_data_nxt;

  // Memory port
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [MEM_W-1:0] mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  logic [MEM_W-1:0] mem_rdata;

  logic                 rd_vld;
  logic [KEY_W-1:0]     rd_key;
  logic [FREQ_BITS-1:0] rd_freq;
  logic [STAMP_W-1:0]   rd_stamp;

  // Shared compare unit operands
  logic [FREQ_BITS-1:0] cmp_a_freq;
  logic [STAMP_W-1:0]   cmp_a_stamp;
  cmp_res_t             cmp_res;

  logic [CMP_W-1:0]         cap_ext;
  logic [CMP_W-1:0]         cap_eff;
  logic [CMP_W-1:0]         cnt_ins;
  logic                     need_evict;
  logic                     new_wins;
  logic [FREQ_BITS-1:0]     freq_inc;
  logic [CNT_W+OCC_W-1:0]   occ_ext;

  llr_mem #(
    .DEPTH (SLOTS),
    .WIDTH (MEM_W),
    .AW    (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rd_vld   = mem_rdata[MEM_W-1];
  assign rd_key   = mem_rdata[MEM_W-2 -: KEY_W];
  assign rd_freq  = mem_rdata[STAMP_W +: FREQ_BITS];
  assign rd_stamp = mem_rdata[STAMP_W-1:0];

  // Scan compares the slot just read; decide compares the new key's entry
  assign cmp_a_freq  = (state_r == ST_DECIDE) ? FREQ_BITS'(1) : rd_freq;
  assign cmp_a_stamp = (state_r == ST_DECIDE) ? stamp_r : rd_stamp;

  llr_cmp #(
    .FREQ_BITS (FREQ_BITS)
  ) u_cmp (
    .a_key   (rd_key),
    .b_key   (key_r),
    .a_freq  (cmp_a_freq),
    .a_stamp (cmp_a_stamp),
    .b_freq  (best_freq_r),
    .b_stamp (best_stamp_r),
    .res     (cmp_res)
  );

  // Effective capacity and eviction test for an insert
  assign cap_ext    = CMP_W'(cap_r);
  assign cap_eff    = (cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext;
  assign cnt_ins    = CMP_W'(cnt_r) + CMP_W'(1);
  assign need_evict = cnt_ins > cap_eff;
  assign new_wins   = !best_r || cmp_res.lt || (cmp_res.eq && (free_idx_r < best_idx_r));
  assign freq_inc   = (&hit_freq_r) ? hit_freq_r : hit_freq_r + FREQ_BITS'(1);
  assign occ_ext    = {{OCC_W{1'b0}}, cnt_r};

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    d_vld_nxt      = 1'b0;
    reqnum_nxt     = reqnum_r;
    cnt_nxt        = cnt_r;
    cap_nxt        = cfg_wr_en ? CAPR_W'(cfg_wr_data) : cap_r;
    out_vld_nxt    = out_vld_r;
    d_idx_nxt      = d_idx_r;
    func_nxt       = func_r;
    key_nxt        = key_r;
    stamp_nxt      = stamp_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    hit_freq_nxt   = hit_freq_r;
    free_nxt       = free_r;
    free_idx_nxt   = free_idx_r;
    best_nxt       = best_r;
    best_idx_nxt   = best_idx_r;
    best_key_nxt   = best_key_r;
    best_freq_nxt  = best_freq_r;
    best_stamp_nxt = best_stamp_r;
    ev_nxt         = ev_r;
    ev_idx_nxt     = ev_idx_r;
    ev_key_nxt     = ev_key_r;
    out_data_nxt   = out_data_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_raddr      = '0;

    // Drop the result once taken
    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r[IDX_W-1:0];
        if (idx_r == SCN_W'(SLOTS - 1)) begin
          idx_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + SCN_W'(1);
        end
      end

      ST_IDLE: begin
        if (in_tvalid) begin
          func_nxt   = in_tuser[0];
          key_nxt    = in_tdata;
          stamp_nxt  = reqnum_r;
          reqnum_nxt = reqnum_r + STAMP_W'(1);
          hit_nxt    = 1'b0;
          free_nxt   = 1'b0;
          best_nxt   = 1'b0;
          idx_nxt    = '0;
          state_nxt  = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // Issue the next slot read; the previous slot's data is here now
        if (idx_r < SCN_W'(SLOTS)) begin
          mem_raddr = idx_r[IDX_W-1:0];
          d_vld_nxt = 1'b1;
          d_idx_nxt = idx_r[IDX_W-1:0];
          idx_nxt   = idx_r + SCN_W'(1);
        end else begin
          state_nxt = ST_DECIDE;
        end
        if (d_vld_r) begin
          if (rd_vld && cmp_res.key_eq && !hit_r) begin
            hit_nxt      = 1'b1;
            hit_idx_nxt  = d_idx_r;
            hit_freq_nxt = rd_freq;
          end
          if (!rd_vld && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = d_idx_r;
          end
          // Strict compare keeps the lowest slot on a full tie
          if (rd_vld && (!best_r || cmp_res.lt)) begin
            best_nxt       = 1'b1;
            best_idx_nxt   = d_idx_r;
            best_key_nxt   = rd_key;
            best_freq_nxt  = rd_freq;
            best_stamp_nxt = rd_stamp;
          end
        end
      end

      ST_DECIDE: begin
        ev_nxt     = 1'b0;
        ev_key_nxt = '0;
        state_nxt  = ST_DONE;
        if (func_r == FUNC_REMOVE) begin
          if (hit_r) begin
            mem_we    = 1'b1;
            mem_waddr = hit_idx_r;
            mem_wdata = {1'b0, key_r, hit_freq_r, stamp_r};
            cnt_nxt   = cnt_r - CNT_W'(1);
          end
        end else if (hit_r) begin
          mem_we    = 1'b1;
          mem_waddr = hit_idx_r;
          mem_wdata = {1'b1, key_r, freq_inc, stamp_r};
        end else begin
          mem_we    = 1'b1;
          mem_waddr = free_idx_r;
          mem_wdata = {1'b1, key_r, FREQ_BITS'(1), stamp_r};
          if (need_evict) begin
            ev_nxt     = 1'b1;
            ev_idx_nxt = new_wins ? free_idx_r : best_idx_r;
            ev_key_nxt = new_wins ? key_r : best_key_r;
            state_nxt  = ST_EVICT;
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
      end

      ST_EVICT: begin
        // Invalidate the victim and forget its count
        mem_we    = 1'b1;
        mem_waddr = ev_idx_r;
        mem_wdata = {1'b0, ev_key_r, {FREQ_BITS{1'b0}}, {STAMP_W{1'b0}}};
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = {{PAD_W{1'b0}}, occ_ext[OCC_W-1:0], ev_key_r, ev_r, hit_r};
          state_nxt    = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      idx_r     <= '0;
      d_vld_r   <= 1'b0;
      reqnum_r  <= '0;
      cnt_r     <= '0;
      cap_r     <= CAPR_W'(ENTRIES);
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      d_vld_r   <= d_vld_nxt;
      reqnum_r  <= reqnum_nxt;
      cnt_r     <= cnt_nxt;
      cap_r     <= cap_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_idx_r      <= d_idx_nxt;
    func_r       <= func_nxt;
    key_r        <= key_nxt;
    stamp_r      <= stamp_nxt;
    hit_r        <= hit_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_freq_r   <= hit_freq_nxt;
    free_r       <= free_nxt;
    free_idx_r   <= free_idx_nxt;
    best_r       <= best_nxt;
    best_idx_r   <= best_idx_nxt;
    best_key_r   <= best_key_nxt;
    best_freq_r  <= best_freq_nxt;
    best_stamp_r <= best_stamp_nxt;
    ev_r         <= ev_nxt;
    ev_idx_r     <= ev_idx_nxt;
    ev_key_r     <= ev_key_nxt;
    out_data_r   <= out_data_nxt;
  end

  // Occupancy between requests never exceeds the slot budget
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (CMP_W'(cnt_r) <= CMP_W'(ENTRIES)))
    else $error("occupancy above ENTRIES");

  // An inserting access always finds a free slot
  a_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DECIDE && func_r == FUNC_ACCESS && !hit_r) |-> free_r)
    else $error("no free slot for insert");

  // Eviction only follows a missing access
  a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVICT) |-> (func_r == FUNC_ACCESS && !hit_r && ev_r))
    else $error("eviction without missing access");

  // An accepted beat starts a scan from slot zero
  a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_SCAN && idx_r == '0))
    else $error("scan did not start after accept");

  // A result with an eviction never reports a hit
  a_out_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_data_r[1]) |-> !out_data_r[0])
    else $error("evict reported with hit");

endmodule

@@ rtl/llr_mem.sv @@
// Single-port-write, single-port-read entry store with registered read data.
// No dependencies.
module llr_mem #(
  parameter int DEPTH = 65,
  parameter int WIDTH = 161,
  parameter int AW    = 7
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/llr_cmp.sv @@
// Shared compare unit: key match and (count, stamp) ordering.
// Depends on llr_pkg.
module llr_cmp #(
  parameter int FREQ_BITS = 32
) (
  input  logic [llr_pkg::KEY_W-1:0]   a_key,
  input  logic [llr_pkg::KEY_W-1:0]   b_key,
  input  logic [FREQ_BITS-1:0]        a_freq,
  input  logic [llr_pkg::STAMP_W-1:0] a_stamp,
  input  logic [FREQ_BITS-1:0]        b_freq,
  input  logic [llr_pkg::STAMP_W-1:0] b_stamp,
  output llr_pkg::cmp_res_t           res
);
  import llr_pkg::*;

  logic freq_lt;
  logic freq_eq;
  logic stamp_lt;
  logic stamp_eq;

  assign freq_lt  = a_freq < b_freq;
  assign freq_eq  = a_freq == b_freq;
  assign stamp_lt = a_stamp < b_stamp;
  assign stamp_eq = a_stamp == b_stamp;

  assign res.lt     = freq_lt || (freq_eq && stamp_lt);
  assign res.eq     = freq_eq && stamp_eq;
  assign res.key_eq = a_key == b_key;

endmodule

@@ verif/tb.sv @@
// Self-checking bench for lfu_lru_replacement_core: LFU eviction with LRU tie-break.
// Depends on llr_pkg and the core RTL. Stream stimulus and a scoreboard fed by an
// in-bench replacement predictor.
`timescale 1ns / 100ps

module tb;
  import llr_pkg::*;

  localparam int ENTRIES   = 64;
  localparam int FREQ_BITS = 32;
  localparam int SLOTS     = ENTRIES + 1;
  localparam int HOLD_CYCLES = 600;   // long receiver hold-off
  localparam int IDLE_LIMIT  = 5000;  // cycles without any beat before giving up
  localparam int MAX_PRINTS  = 40;

  // One result beat, unpacked
  typedef struct packed {
    logic                hit;
    logic                evict_valid;
    logic [KEY_W-1:0]    evict_key;
    logic [OCC_W-1:0]    occupancy;
  } lookup_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [KEY_W-1:0]     in_tdata;
  logic [0:0]           in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [OUT_W-1:0]     out_tdata;
  logic                 cfg_wr_en;
  logic [CAP_W-1:0]     cfg_wr_data;

  // Shadow of the key table
  logic                 slot_valid [SLOTS];
  logic [KEY_W-1:0]     slot_key   [SLOTS];
  logic [FREQ_BITS-1:0] slot_count [SLOTS];
  logic [STAMP_W-1:0]   slot_stamp [SLOTS];
  logic [STAMP_W-1:0]   req_seq;
  int                   live_keys;
  logic [CAP_W-1:0]     capacity_q;

  lookup_t lookups_in_flight[$];

  int err_count;
  int burst_left;
  int gap_max;
  bit hold_req;
  int stall_mode;
  int stall_tick;
  int idle_cycles;
  int n_requests, n_hits, n_evictions, n_removes, n_cap_writes, n_holds;

  lfu_lru_replacement_core #(
    .ENTRIES  (ENTRIES),
    .FREQ_BITS(FREQ_BITS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor: apply one request to the shadow table and return its result.
  // Hit bumps the count (saturating) and restamps; miss inserts with count 1,
  // then evicts the lowest count, oldest stamp, lowest slot if over capacity.
  // ---------------------------------------------------------------------------
  function automatic lookup_t lookup_and_replace(logic func, logic [KEY_W-1:0] key);
    lookup_t            r;
    int                 found;
    int                 free_slot;
    int                 victim;
    int                 eff_cap;
    int                 i;
    logic [STAMP_W-1:0] stamp;
    r         = '0;
    found     = -1;
    free_slot = -1;
    victim    = -1;
    stamp     = req_seq;
    req_seq   = req_seq + 1'b1;
    eff_cap   = (capacity_q > ENTRIES) ? ENTRIES : int'(capacity_q);
    for (i = 0; i < SLOTS; i++)
      if (found < 0 && slot_valid[i] && slot_key[i] == key) found = i;
    r.hit = (found >= 0);
    if (func == FUNC_REMOVE) begin
      n_removes++;
      if (found >= 0) begin
        slot_valid[found] = 1'b0;
        live_keys--;
      end
    end else if (found >= 0) begin
      if (slot_count[found] != '1) slot_count[found] = slot_count[found] + 1'b1;
      slot_stamp[found] = stamp;
    end else begin
      for (i = 0; i < SLOTS; i++)
        if (free_slot < 0 && !slot_valid[i]) free_slot = i;
      slot_valid[free_slot] = 1'b1;
      slot_key[free_slot]   = key;
      slot_count[free_slot] = 1;
      slot_stamp[free_slot] = stamp;
      live_keys++;
      if (live_keys > eff_cap) begin
        for (i = 0; i < SLOTS; i++) begin
          if (!slot_valid[i]) continue;
          if (victim < 0 || slot_count[i] < slot_count[victim] ||
              (slot_count[i] == slot_count[victim] && slot_stamp[i] < slot_stamp[victim]))
            victim = i;
        end
        r.evict_valid       = 1'b1;
        r.evict_key         = slot_key[victim];
        slot_valid[victim]  = 1'b0;
        slot_count[victim]  = '0;
        live_keys--;
        n_evictions++;
      end
    end
    if (r.hit) n_hits++;
    r.occupancy = live_keys[OCC_W-1:0];
    return r;
  endfunction

  function automatic void clear_shadow();
    int i;
    for (i = 0; i < SLOTS; i++) begin
      slot_valid[i] = 1'b0;
      slot_key[i]   = '0;
      slot_count[i] = '0;
      slot_stamp[i] = '0;
    end
    req_seq    = '0;
    live_keys  = 0;
    capacity_q = CAP_W'(ENTRIES);
  endfunction

  task automatic flag_lookup_error(string what, logic [KEY_W-1:0] got, logic [KEY_W-1:0] want);
    if (err_count < MAX_PRINTS)
      $display("[%0t] MISMATCH %s: got %h want %h", $realtime, what, got, want);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Scoreboard: compare each accepted result beat with the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    lookup_t got;
    lookup_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.hit         = out_tdata[0];
      got.evict_valid = out_tdata[1];
      got.evict_key   = out_tdata[65:2];
      got.occupancy   = out_tdata[72:66];
      if (lookups_in_flight.size() == 0) begin
        flag_lookup_error("result beat with no request outstanding", out_tdata[63:0], '0);
      end else begin
        want = lookups_in_flight.pop_front();
        if (got.hit != want.hit)
          flag_lookup_error("hit", got.hit, want.hit);
        if (got.evict_valid != want.evict_valid)
          flag_lookup_error("evict_valid", got.evict_valid, want.evict_valid);
        if (got.evict_key != want.evict_key)
          flag_lookup_error("evict_key", got.evict_key, want.evict_key);
        if (got.occupancy != want.occupancy)
          flag_lookup_error("occupancy", got.occupancy, want.occupancy);
      end
    end
  end

  // Watchdog: give up when no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no beat for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, lookups_in_flight.size());
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall on a changing pattern; on request, hold off for a long
  // stretch so the core fills up and drops in_tready.
  // ---------------------------------------------------------------------------
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        n_holds++;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall_tick++;
        if (stall_tick % 400 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 9) > 2);
          2: out_tready <= ((stall_tick % 16) < 11);
          default: out_tready <= ($urandom_range(0, 9) > 6);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: one request beat, preceded by a random gap at each burst boundary.
  // Valid stays high after the beat so back-to-back requests need no toggle.
  // ---------------------------------------------------------------------------
  task automatic send_request(logic func, logic [KEY_W-1:0] key);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, gap_max);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= key;
    in_tuser  <= func;
    do @(posedge clk); while (!in_tready);
    n_requests++;
    lookups_in_flight.push_back(lookup_and_replace(func, key));
  endtask

  // Drop valid and hold until every predicted result has come back.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (lookups_in_flight.size() != 0 || !in_tready) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    capacity_q = value;
    n_cap_writes++;
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Extreme keys, hit and miss, remove of a present, a just-removed and a
  // never-seen key, at the reset capacity.
  task automatic test_access_and_remove();
    gap_max = 2;
    send_request(FUNC_ACCESS, 64'h0);
    send_request(FUNC_ACCESS, '1);
    send_request(FUNC_ACCESS, 64'h0);
    send_request(FUNC_ACCESS, 64'hAAAA_AAAA_AAAA_AAAA);
    send_request(FUNC_REMOVE, '1);
    send_request(FUNC_REMOVE, '1);
    send_request(FUNC_REMOVE, 64'h5555_5555_5555_5555);
    send_request(FUNC_ACCESS, '1);
  endtask

  // Capacity below occupancy, capacity zero (a miss can evict itself), equal
  // counts resolved by age, and capacity above the table size.
  // A saturating count needs 2^FREQ_BITS-2 hits on one key and is out of reach.
  task automatic test_capacity_edges();
    write_capacity(7'd1);
    send_request(FUNC_ACCESS, 64'h1111_0000_0000_1111);
    send_request(FUNC_ACCESS, 64'h0);
    send_request(FUNC_REMOVE, '1);
    write_capacity(7'd0);
    send_request(FUNC_ACCESS, 64'h2222_0000_0000_2222);
    send_request(FUNC_ACCESS, 64'h3333_0000_0000_3333);
    send_request(FUNC_ACCESS, 64'h0);
    write_capacity(7'd2);
    send_request(FUNC_ACCESS, 64'h4444_0000_0000_4444);
    send_request(FUNC_ACCESS, 64'h5555_0000_0000_5555);
    send_request(FUNC_ACCESS, 64'h6666_0000_0000_6666);
    write_capacity(7'd127);
    send_request(FUNC_ACCESS, 64'h7777_0000_0000_7777);
    send_request(FUNC_ACCESS, 64'h0);
    send_request(FUNC_REMOVE, 64'h0);
  endtask

  // Hold the receiver off while requests keep coming: the core must stall input.
  task automatic test_backpressure();
    logic [KEY_W-1:0] keys [5];
    int i;
    for (i = 0; i < 5; i++) keys[i] = {$urandom, $urandom};
    gap_max  = 0;
    hold_req = 1'b1;
    for (i = 0; i < 16; i++)
      send_request(($urandom_range(0, 7) == 0) ? FUNC_REMOVE : FUNC_ACCESS, keys[i % 5]);
    wait_drained();
  endtask

  // Sender pauses mid-stream until every result has come back, then resumes.
  task automatic test_pause_until_drained();
    int i;
    gap_max = 3;
    for (i = 0; i < 10; i++) send_request(FUNC_ACCESS, {56'h0, 8'(i)});
    wait_drained();
    for (i = 0; i < 10; i++) send_request(FUNC_ACCESS, {56'h0, 8'(i * 3)});
    wait_drained();
  endtask

  // One capacity setting: prime the table with a key pool slightly larger than
  // capacity, then mostly pool traffic with random removes and stray keys.
  task automatic run_random_phase(logic [CAP_W-1:0] cap, int n_items, int gaps);
    logic [KEY_W-1:0] pool [$];
    logic [KEY_W-1:0] key;
    int eff, pool_n, r, i;
    write_capacity(cap);
    gap_max = gaps;
    eff     = (cap > ENTRIES) ? ENTRIES : int'(cap);
    pool_n  = eff + $urandom_range(1, eff / 4 + 2);
    for (i = 0; i < pool_n; i++) pool.push_back({$urandom, $urandom});
    foreach (pool[j]) send_request(FUNC_ACCESS, pool[j]);
    for (i = 0; i < n_items; i++) begin
      r   = $urandom_range(0, 99);
      key = pool[$urandom_range(0, pool_n - 1)];
      if (r < 72)      send_request(FUNC_ACCESS, key);
      else if (r < 86) send_request(FUNC_REMOVE, key);
      else if (r < 93) send_request(FUNC_ACCESS, {$urandom, $urandom});
      else if (r < 96) send_request(FUNC_REMOVE, {$urandom, $urandom});
      else             send_request($urandom_range(0, 1) ? FUNC_REMOVE : FUNC_ACCESS,
                                    $urandom_range(0, 1) ? '1 : '0);
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(7'd64, 135, 0);
    run_random_phase(7'd1, 135, 6);
    run_random_phase(7'd16, 135, 3);
    run_random_phase(7'd0, 135, 6);
    run_random_phase(7'd127, 135, 0);
    run_random_phase(7'd3, 135, 4);
    run_random_phase(CAP_W'($urandom_range(1, 64)), 135, 6);
    run_random_phase(7'd64, 135, 2);
    run_random_phase(CAP_W'($urandom_range(0, 127)), 135, 5);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= CAP_W'(ENTRIES);
    hold_req    = 1'b0;
    stall_mode  = 0;
    idle_cycles = 0;
    clear_shadow();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_access_and_remove();
    test_capacity_edges();
    test_backpressure();
    test_pause_until_drained();
    test_random_traffic();

    // Let any stray beat show up before the verdict.
    wait_drained();
    repeat (ENTRIES + 10) @(posedge clk);

    $display("Covered %0d requests: %0d hits, %0d evictions, %0d removes",
             n_requests, n_hits, n_evictions, n_removes);
    $display("Capacity written %0d times, receiver held off %0d time(s), %0d mismatches",
             n_cap_writes, n_holds, err_count);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
